// ----- rtl/kst_pkg.sv -----
// Shared constants, codes and types of the keyed slot table.
`default_nettype none
package kst_pkg;

   localparam int DEPTH    = 128;
   localparam int KEY_BITS = 64;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   localparam int CSR_W    = 8;
   localparam int KEY_W    = 64;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 7;

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(128);

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_UPDATED   = 3'd0,
      STAT_PLACED    = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_FREED     = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [KEY_BITS-1:0] key;
      logic [DATA_W-1:0]   data;
   } mem_wr_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/kst_if.sv -----
// Valid/ready channel interfaces for requests, responses and the count register.
`default_nettype none
interface kst_req_if;
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [kst_pkg::KEY_W-1:0]       key;
   logic signed [kst_pkg::DATA_W-1:0] data;
   modport source (output valid, func, key, data, input ready);
   modport sink   (input valid, func, key, data, output ready);
endinterface

interface kst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kst_pkg::STATUS_W-1:0] status;
   logic [kst_pkg::SLOT_W-1:0]   slot;
   modport source (output valid, status, slot, input ready);
   modport sink   (input valid, status, slot, output ready);
endinterface

interface kst_csr_if;
   logic                      valid;
   logic                      ready;
   logic [kst_pkg::CSR_W-1:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/keyed_slot_table_alloc_free_core.sv -----
// Top level of the keyed slot table: count register, sequencer, storage and response register.
// One request scans the first n slots of the key memory, where n is the active count (the count
// register limited to the table depth); one slot key is read from the key memory per cycle.
// Requests are handled one at a time, and a result is held while the previous response waits. Reset
// clears every valid mark at once, sets the count register to 128 and leaves the memories.
`default_nettype none
module keyed_slot_table_alloc_free_core (
   input  wire logic clock,
   input  wire logic reset,
   kst_req_if.sink   req_ch,
   kst_rsp_if.source rsp_ch,
   kst_csr_if.sink   csr_ch
);

   logic [kst_pkg::CSR_W-1:0]    csr_ff, csr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   kst_pkg::result_type          rsp_res_ff, rsp_res_in;
   logic [kst_pkg::CNT_W-1:0]    count;
   logic                         out_free;
   logic [kst_pkg::KEY_BITS-1:0] rd_key;
   logic [kst_pkg::ADDR_W-1:0]   rd_addr;
   kst_pkg::mem_wr_type          mem_wr;
   logic                         res_valid;
   kst_pkg::result_type          res;

   assign csr_ch.ready = 1'b1;
   assign csr_in       = (csr_ch.valid && csr_ch.ready) ? csr_ch.wdata : csr_ff;

   assign count = (csr_ff > kst_pkg::DEPTH) ? kst_pkg::CNT_W'(kst_pkg::DEPTH)
                                            : kst_pkg::CNT_W'(csr_ff);

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_res_in   = res_valid ? res : rsp_res_ff;

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_res_ff.status;
   assign rsp_ch.slot   = rsp_res_ff.slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= kst_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .count     (count),
      .out_free  (out_free),
      .rd_key    (rd_key),
      .rd_addr   (rd_addr),
      .mem_wr    (mem_wr),
      .res_valid (res_valid),
      .res       (res)
   );

   kst_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_key  (rd_key)
   );

endmodule
`default_nettype wire

// ----- rtl/kst_mem.sv -----
// Key and data storage with one write port and one registered key read port.
`default_nettype none
module kst_mem (
   input  wire logic                            clock,
   input  wire kst_pkg::mem_wr_type             wr,
   input  wire logic [kst_pkg::ADDR_W-1:0]      rd_addr,
   output logic      [kst_pkg::KEY_BITS-1:0]    rd_key
);

   logic [kst_pkg::KEY_BITS-1:0] key_mem  [kst_pkg::DEPTH];
   logic [kst_pkg::DATA_W-1:0]   data_mem [kst_pkg::DEPTH];
   logic [kst_pkg::KEY_BITS-1:0] rd_key_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr]  <= wr.key;
         data_mem[wr.addr] <= wr.data;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   assign rd_key = rd_key_ff;

endmodule
`default_nettype wire

// ----- rtl/kst_ctrl.sv -----
// Request sequencer: scans the key memory, tracks valid marks and resolves each request.
`default_nettype none
module kst_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   kst_req_if.sink                            req_ch,
   input  wire logic [kst_pkg::CNT_W-1:0]     count,
   input  wire logic                          out_free,
   input  wire logic [kst_pkg::KEY_BITS-1:0]  rd_key,
   output logic      [kst_pkg::ADDR_W-1:0]    rd_addr,
   output kst_pkg::mem_wr_type                mem_wr,
   output logic                               res_valid,
   output kst_pkg::result_type                res
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic                         func_ff, func_in;
   logic [kst_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [kst_pkg::DATA_W-1:0]   data_ff, data_in;
   logic [kst_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [kst_pkg::CNT_W-1:0]    issue_ff, issue_in;
   logic                         cmp_vld_ff, cmp_vld_in;
   logic [kst_pkg::ADDR_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [kst_pkg::DEPTH-1:0]    valid_ff, valid_in;
   logic                         hit_ff, hit_in;
   logic [kst_pkg::ADDR_W-1:0]   hit_idx_ff, hit_idx_in;
   logic                         free_ff, free_in;
   logic [kst_pkg::ADDR_W-1:0]   free_idx_ff, free_idx_in;

   logic accept;
   logic slot_vld;
   logic key_eq;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rd_addr      = issue_ff[kst_pkg::ADDR_W-1:0];
   assign slot_vld     = valid_ff[cmp_idx_ff];
   assign key_eq       = (rd_key == key_ff);

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      key_in      = key_ff;
      data_in     = data_ff;
      cnt_in      = cnt_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      valid_in    = valid_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      mem_wr      = '0;
      res_valid   = 1'b0;
      res.status  = kst_pkg::STAT_FULL;
      res.slot    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in  = req_ch.func;
               key_in   = req_ch.key[kst_pkg::KEY_BITS-1:0];
               data_in  = req_ch.data;
               cnt_in   = count;
               issue_in = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff < cnt_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[kst_pkg::ADDR_W-1:0];
               issue_in   = issue_ff + kst_pkg::CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               state_in = S_DONE;
            end
            if (cmp_vld_ff) begin
               if (func_ff == kst_pkg::FUNC_FREE) begin
                  if (slot_vld && key_eq) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                     if (!hit_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = cmp_idx_ff;
                     end
                  end
               end else begin
                  if (slot_vld && key_eq && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cmp_idx_ff;
                  end
                  if (!slot_vld && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
               if (func_ff == kst_pkg::FUNC_FREE) begin
                  if (hit_ff) begin
                     res.status = kst_pkg::STAT_FREED;
                     res.slot   = kst_pkg::SLOT_W'(hit_idx_ff);
                  end else begin
                     res.status = kst_pkg::STAT_NOT_FOUND;
                  end
               end else if (hit_ff) begin
                  res.status  = kst_pkg::STAT_UPDATED;
                  res.slot    = kst_pkg::SLOT_W'(hit_idx_ff);
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = hit_idx_ff;
                  mem_wr.key  = key_ff;
                  mem_wr.data = data_ff;
               end else if (free_ff) begin
                  res.status  = kst_pkg::STAT_PLACED;
                  res.slot    = kst_pkg::SLOT_W'(free_idx_ff);
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = free_idx_ff;
                  mem_wr.key  = key_ff;
                  mem_wr.data = data_ff;
                  valid_in[free_idx_ff] = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      data_ff     <= data_in;
      cnt_ff      <= cnt_in;
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

endmodule
`default_nettype wire

// ----- dv/tb_keyed_slot_table_alloc_free_core.sv -----
// Testbench of the keyed slot table: directed and random requests checked against a slot table model.
`timescale 1ns / 1ps

class slot_table_tracker;
   bit                           occupied [kst_pkg::DEPTH];
   logic [kst_pkg::KEY_BITS-1:0] slot_key [kst_pkg::DEPTH];
   logic [kst_pkg::DATA_W-1:0]   slot_data [kst_pkg::DEPTH];
   int                           active_limit;
   kst_pkg::result_type          pending_results [$];
   int                           fault_count;

   function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      active_limit = kst_pkg::DEPTH;
      fault_count  = 0;
   endfunction

   function void report_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch %0d: %s", fault_count, msg);
   endfunction

   function void set_count(logic [kst_pkg::CSR_W-1:0] value);
      active_limit = (int'(value) > kst_pkg::DEPTH) ? kst_pkg::DEPTH : int'(value);
   endfunction

   function void note_request(kst_pkg::func_type op, logic [kst_pkg::KEY_W-1:0] key_in,
                              logic [kst_pkg::DATA_W-1:0] data_in);
      kst_pkg::result_type          outcome;
      logic [kst_pkg::KEY_BITS-1:0] key_cut;
      int                           hit_at;
      int                           open_at;
      int                           i;
      key_cut = key_in[kst_pkg::KEY_BITS-1:0];
      hit_at  = -1;
      open_at = -1;
      if (op == kst_pkg::FUNC_ALLOC) begin
         for (i = 0; i < active_limit; i++) begin
            if (occupied[i]) begin
               if (hit_at < 0 && slot_key[i] == key_cut) hit_at = i;
            end else if (open_at < 0) begin
               open_at = i;
            end
         end
         if (hit_at >= 0) begin
            slot_data[hit_at] = data_in;
            outcome.status = kst_pkg::STAT_UPDATED;
            outcome.slot   = kst_pkg::SLOT_W'(hit_at);
         end else if (open_at >= 0) begin
            slot_key[open_at]  = key_cut;
            slot_data[open_at] = data_in;
            occupied[open_at]  = 1'b1;
            outcome.status = kst_pkg::STAT_PLACED;
            outcome.slot   = kst_pkg::SLOT_W'(open_at);
         end else begin
            outcome.status = kst_pkg::STAT_FULL;
            outcome.slot   = '0;
         end
      end else begin
         for (i = 0; i < active_limit; i++) begin
            if (occupied[i] && slot_key[i] == key_cut) begin
               if (hit_at < 0) hit_at = i;
               occupied[i] = 1'b0;
            end
         end
         if (hit_at >= 0) begin
            outcome.status = kst_pkg::STAT_FREED;
            outcome.slot   = kst_pkg::SLOT_W'(hit_at);
         end else begin
            outcome.status = kst_pkg::STAT_NOT_FOUND;
            outcome.slot   = '0;
         end
      end
      pending_results.push_back(outcome);
   endfunction

   function void check_result(logic [kst_pkg::STATUS_W-1:0] status_in,
                              logic [kst_pkg::SLOT_W-1:0] slot_in);
      kst_pkg::result_type want;
      if (pending_results.size() == 0) begin
         report_fault($sformatf("response with none pending: status %0d slot %0d",
                                status_in, slot_in));
         return;
      end
      want = pending_results.pop_front();
      if (status_in !== want.status)
         report_fault($sformatf("status expected %0d actual %0d", want.status, status_in));
      if (slot_in !== want.slot)
         report_fault($sformatf("slot expected %0d actual %0d", want.slot, slot_in));
   endfunction
endclass

module tb_keyed_slot_table_alloc_free_core;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 140;
   localparam int PHASES      = 8;
   localparam int POOL_SIZE   = 400;
   localparam int PHASE_COUNT [PHASES] = '{128, 7, 1, 255, 2, 33, 200, 128};
   localparam int PHASE_POOL  [PHASES] = '{12, 10, 3, 400, 4, 40, 140, 20};
   localparam int PHASE_ITEMS [PHASES] = '{60, 50, 40, 200, 40, 50, 100, 60};
   localparam int PHASE_ALLOC [PHASES] = '{60, 60, 55, 90, 55, 60, 80, 50};

   logic clock;
   logic reset;
   bit   quiet = 1'b0;
   int   hold_request = 0;
   int   idle_cycles = 0;

   kst_req_if req_ch ();
   kst_rsp_if rsp_ch ();
   kst_csr_if csr_ch ();

   slot_table_tracker tracker = new();

   keyed_slot_table_alloc_free_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1) tracker.set_count(csr_ch.wdata);
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            tracker.note_request(kst_pkg::func_type'(req_ch.func), req_ch.key, req_ch.data);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.check_result(rsp_ch.status, rsp_ch.slot);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : response_sink
      int gap;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_request > 0) begin
            gap = hold_request;
            hold_request = 0;
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   task automatic offer_request(kst_pkg::func_type op, logic [kst_pkg::KEY_W-1:0] key_in,
                                logic [kst_pkg::DATA_W-1:0] data_in);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= op;
      req_ch.key   <= key_in;
      req_ch.data  <= data_in;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_results.size() != 0);
   endtask

   task automatic write_count(logic [kst_pkg::CSR_W-1:0] value);
      settle();
      csr_ch.valid <= 1'b1;
      csr_ch.wdata <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [kst_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
      logic [kst_pkg::KEY_W-1:0] seed_keys [4];
      logic [kst_pkg::KEY_W-1:0] pick;
      kst_pkg::func_type         op;
      int                        p;
      int                        n;

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func  <= kst_pkg::FUNC_ALLOC;
      req_ch.key   <= '0;
      req_ch.data  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.wdata <= '0;
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      seed_keys[0] = 64'h0123_4567_89ab_cdef;
      seed_keys[1] = 64'hfedc_ba98_7654_3210;
      seed_keys[2] = 64'h5a5a_5a5a_a5a5_a5a5;
      seed_keys[3] = 64'h0000_0001_0000_0001;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_request(kst_pkg::FUNC_ALLOC, '0, 32'h8000_0000);
      offer_request(kst_pkg::FUNC_ALLOC, '1, 32'h7fff_ffff);
      offer_request(kst_pkg::FUNC_ALLOC, '0, 32'hffff_ffff);
      offer_request(kst_pkg::FUNC_FREE, '1, '0);
      offer_request(kst_pkg::FUNC_FREE, '1, 32'h5555_aaaa);
      offer_request(kst_pkg::FUNC_FREE, '0, '0);
      write_count(8'd0);
      offer_request(kst_pkg::FUNC_ALLOC, seed_keys[0], 32'h1);
      offer_request(kst_pkg::FUNC_FREE, seed_keys[0], '0);
      write_count(8'd4);
      foreach (seed_keys[i]) offer_request(kst_pkg::FUNC_ALLOC, seed_keys[i], $urandom);
      offer_request(kst_pkg::FUNC_ALLOC, 64'hdead_beef_0000_0001, $urandom);
      offer_request(kst_pkg::FUNC_FREE, seed_keys[0], $urandom);
      // Hiding slot 3 lets its key be placed again in slot 0, leaving the key in two slots.
      write_count(8'd3);
      offer_request(kst_pkg::FUNC_ALLOC, seed_keys[3], $urandom);
      write_count(8'd4);
      offer_request(kst_pkg::FUNC_ALLOC, seed_keys[3], $urandom);
      offer_request(kst_pkg::FUNC_FREE, seed_keys[3], $urandom);
      offer_request(kst_pkg::FUNC_ALLOC, seed_keys[3], $urandom);
      write_count(8'd255);
      offer_request(kst_pkg::FUNC_ALLOC, 64'h8000_0000_0000_0000, 32'h0);

      for (p = 0; p < PHASES; p++) begin
         write_count(kst_pkg::CSR_W'(PHASE_COUNT[p]));
         quiet = (p == 4) || (p == 7);
         if (p == 1) hold_request = LONG_HOLD;
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            if (p == 2 && n == PHASE_ITEMS[p] / 2) settle();
            if ($urandom_range(0, 99) < 5) pick = {$urandom, $urandom};
            else pick = key_pool[$urandom_range(0, PHASE_POOL[p] - 1)];
            op = ($urandom_range(0, 99) < PHASE_ALLOC[p]) ? kst_pkg::FUNC_ALLOC
                                                          : kst_pkg::FUNC_FREE;
            offer_request(op, pick, $urandom);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.pending_results.size() != 0)
         tracker.report_fault($sformatf("%0d responses never arrived",
                                        tracker.pending_results.size()));
      if (tracker.fault_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/kst_pkg.sv
rtl/kst_if.sv
rtl/kst_mem.sv
rtl/kst_ctrl.sv
rtl/keyed_slot_table_alloc_free_core.sv
dv/tb_keyed_slot_table_alloc_free_core.sv
